@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/mabs_pkg.sv @@
package mabs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int STEP_WIDTH  = 24;
    localparam int AXES        = 5;
    localparam int FIELD_W     = 24;
    localparam int EXT_W       = (FIELD_W > STEP_WIDTH) ? FIELD_W : STEP_WIDTH;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ACC_W       = STEP_WIDTH + 1;
    localparam int REM_W       = STEP_WIDTH + 3;
    localparam int CNT_W       = $clog2(AXES + 1);

    // item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef logic [STEP_WIDTH-1:0] step_t;
    typedef logic [ACC_W-1:0]      acc_t;
    typedef logic [REM_W-1:0]      rem_t;

    // one queued block, with its event count and total pulse count precomputed
    typedef struct packed {
        step_t [AXES-1:0] steps;
        step_t            top;
        rem_t             total;
    } qentry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } qctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef struct packed {
        logic  start;    // block activates this tick
        logic  advance;  // tick with an active block
        step_t top;      // event count in force this tick
    } lane_ctl_t;

    function automatic step_t to_step(input logic [FIELD_W-1:0] v);
        logic [EXT_W-1:0] t;
        begin
            t = EXT_W'(v);
            return t[STEP_WIDTH-1:0];
        end
    endfunction

endpackage

@@ rtl/mabs_queue.sv @@
module mabs_queue (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  mabs_pkg::qctl_t                          ctl,
    input  mabs_pkg::step_t [mabs_pkg::AXES-1:0]     push_steps,
    output mabs_pkg::qstat_t                         stat,
    output mabs_pkg::qentry_t                        head
);

    mabs_pkg::qentry_t                   rows_reg [mabs_pkg::QUEUE_DEPTH];
    mabs_pkg::qentry_t                   push_entry;
    logic [mabs_pkg::PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [mabs_pkg::PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [mabs_pkg::FILL_W-1:0]         fill_reg, fill_next;

    // max and sum done on the way in, so activation is a plain read
    always_comb
    begin
        push_entry.steps = push_steps;
        push_entry.top   = '0;
        push_entry.total = '0;
        for (int a = 0; a < mabs_pkg::AXES; a++)
        begin
            if (push_steps[a] > push_entry.top)
            begin
                push_entry.top = push_steps[a];
            end
            push_entry.total = push_entry.total + mabs_pkg::REM_W'(push_steps[a]);
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (ctl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == mabs_pkg::PTR_W'(mabs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mabs_pkg::PTR_W'(mabs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            rows_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = rows_reg[rd_ptr_reg];
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == mabs_pkg::FILL_W'(mabs_pkg::QUEUE_DEPTH));

endmodule

@@ rtl/mabs_lane.sv @@
module mabs_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mabs_pkg::lane_ctl_t   ctl,
    input  mabs_pkg::step_t       start_step,
    output logic                  pulse
);

    mabs_pkg::step_t              steps_reg;
    mabs_pkg::acc_t               acc_reg, acc_next;
    mabs_pkg::step_t              steps_eff;
    mabs_pkg::acc_t               acc_eff;
    logic [mabs_pkg::ACC_W:0]     sum_w;
    logic [mabs_pkg::ACC_W:0]     top_w;

    always_comb
    begin
        steps_eff = ctl.start ? start_step : steps_reg;
        acc_eff   = ctl.start ? mabs_pkg::ACC_W'(ctl.top >> 1) : acc_reg;
        top_w     = (mabs_pkg::ACC_W + 1)'(ctl.top);
        sum_w     = {1'b0, acc_eff} + (mabs_pkg::ACC_W + 1)'(steps_eff);
        pulse     = ctl.advance && (sum_w > top_w);
        acc_next  = (sum_w > top_w) ? mabs_pkg::ACC_W'(sum_w - top_w)
                                    : mabs_pkg::ACC_W'(sum_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            if (ctl.start)
            begin
                steps_reg <= start_step;
            end
            if (ctl.advance)
            begin
                acc_reg <= acc_next;
            end
        end
    end

endmodule

@@ rtl/multi_axis_bresenham_stepper.sv @@
// Channel   Handshake              Payload
// -------   --------------------   --------------------------------------------
// cmd       cmd_valid / cmd_stall  op, steps_x, steps_y, steps_z, steps_a, steps_c
// rsp       rsp_valid / rsp_stall  step_bits, block_done, idle, load_rejected
//
// One item per clock while cmd_stall is low; every item gives one result in the cycle after acceptance.
// The rate is set by the per-axis accumulate/compare in each lane, which
// is combinational; block max and sum are formed when a block is queued.
// rst_n clears pointers, fill count, active flag, lane state and the result
// valid flag at once; result data and queue rows need no clearing pass.
// cmd_stall is high only while a result is held and rsp_stall is high.
module multi_axis_bresenham_stepper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  logic                                 op,
    input  logic [mabs_pkg::FIELD_W-1:0]         steps_x,
    input  logic [mabs_pkg::FIELD_W-1:0]         steps_y,
    input  logic [mabs_pkg::FIELD_W-1:0]         steps_z,
    input  logic [mabs_pkg::FIELD_W-1:0]         steps_a,
    input  logic [mabs_pkg::FIELD_W-1:0]         steps_c,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic [mabs_pkg::AXES-1:0]            step_bits,
    output logic                                 block_done,
    output logic                                 idle,
    output logic                                 load_rejected
);

    // handshake
    logic                                  accept;
    logic                                  is_load;
    logic                                  is_tick;

    // queue side
    mabs_pkg::qctl_t                       q_ctl;
    mabs_pkg::qstat_t                      q_stat;
    mabs_pkg::qentry_t                     q_head;
    mabs_pkg::step_t [mabs_pkg::AXES-1:0]  push_steps;

    // block control
    logic                                  block_active_reg, block_active_next;
    mabs_pkg::step_t                       event_reg, event_next;
    mabs_pkg::rem_t                        rem_reg, rem_next;
    mabs_pkg::rem_t                        rem_eff;
    logic                                  activate;
    logic                                  eff_active;
    mabs_pkg::lane_ctl_t                   lane_ctl;
    logic [mabs_pkg::AXES-1:0]             pulses;
    logic [mabs_pkg::CNT_W-1:0]            pulse_cnt;
    logic                                  done_now;

    // result register
    logic                                  rsp_valid_reg, rsp_valid_next;
    logic [mabs_pkg::AXES-1:0]             step_bits_reg, step_bits_next;
    logic                                  done_reg, done_next;
    logic                                  idle_reg, idle_next;
    logic                                  rej_reg, rej_next;

    // The result register frees up in the same cycle it is taken.
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_load   = accept && (op == mabs_pkg::OP_LOAD);
    assign is_tick   = accept && (op == mabs_pkg::OP_TICK);

    assign push_steps[0] = mabs_pkg::to_step(steps_x);
    assign push_steps[1] = mabs_pkg::to_step(steps_y);
    assign push_steps[2] = mabs_pkg::to_step(steps_z);
    assign push_steps[3] = mabs_pkg::to_step(steps_a);
    assign push_steps[4] = mabs_pkg::to_step(steps_c);

    // A tick with no active block pulls the head block and runs it right away.
    assign activate   = is_tick && !block_active_reg && !q_stat.empty;
    assign eff_active = block_active_reg || activate;

    assign q_ctl.push = is_load && !q_stat.full;
    assign q_ctl.pop  = activate;

    mabs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (q_ctl),
        .push_steps (push_steps),
        .stat       (q_stat),
        .head       (q_head)
    );

    assign lane_ctl.start   = activate;
    assign lane_ctl.advance = is_tick && eff_active;
    assign lane_ctl.top     = activate ? q_head.top : event_reg;

    for (genvar g = 0; g < mabs_pkg::AXES; g++)
    begin : g_lane
        mabs_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl),
            .start_step (q_head.steps[g]),
            .pulse      (pulses[g])
        );
    end

    // Merge: count pulses, retire them from the remaining count.
    always_comb
    begin
        pulse_cnt = '0;
        for (int a = 0; a < mabs_pkg::AXES; a++)
        begin
            pulse_cnt = pulse_cnt + mabs_pkg::CNT_W'(pulses[a]);
        end
        rem_eff  = activate ? q_head.total : rem_reg;
        // saturating decrement: remaining never goes below zero
        done_now = (rem_eff <= mabs_pkg::REM_W'(pulse_cnt));

        block_active_next = block_active_reg;
        event_next        = event_reg;
        rem_next          = rem_reg;
        if (lane_ctl.advance)
        begin
            block_active_next = !done_now;
            event_next        = lane_ctl.top;
            rem_next          = done_now ? '0 : rem_eff - mabs_pkg::REM_W'(pulse_cnt);
        end
    end

    always_comb
    begin
        step_bits_next = step_bits_reg;
        done_next      = done_reg;
        idle_next      = idle_reg;
        rej_next       = rej_reg;
        rsp_valid_next = rsp_stall ? rsp_valid_reg : 1'b0;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            step_bits_next = pulses;
            done_next      = lane_ctl.advance && done_now;
            idle_next      = is_tick && !eff_active;
            rej_next       = is_load && q_stat.full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_active_reg <= 1'b0;
            event_reg        <= '0;
            rem_reg          <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            block_active_reg <= block_active_next;
            event_reg        <= event_next;
            rem_reg          <= rem_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_bits_reg <= step_bits_next;
        done_reg      <= done_next;
        idle_reg      <= idle_next;
        rej_reg       <= rej_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign step_bits     = step_bits_reg;
    assign block_done    = done_reg;
    assign idle          = idle_reg;
    assign load_rejected = rej_reg;

endmodule

@@ rtl/mabs_checker.sv @@
`include "assert_macros.svh"

module mabs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_stall,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic [mabs_pkg::AXES-1:0]      step_bits,
    input  logic                           block_done,
    input  logic                           idle,
    input  logic                           load_rejected
);

    // an accepted item always shows up as a result next cycle
    `ASSERT_NEXT(a_item_to_result, clk, rst_n, cmd_valid && !cmd_stall, rsp_valid)

    // input only backs up behind a held result
    `ASSERT_SAME(a_stall_cause, clk, rst_n, cmd_stall, rsp_valid && rsp_stall)

    // a rejected load result carries no tick flags
    `ASSERT_SAME(a_load_clean, clk, rst_n, rsp_valid && load_rejected,
                 step_bits == '0 && !block_done && !idle)

    // an idle tick neither pulses nor finishes a block
    `ASSERT_SAME(a_idle_clean, clk, rst_n, rsp_valid && idle,
                 step_bits == '0 && !block_done)

    // a held result stays put
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
                 rsp_valid && $stable(step_bits) && $stable(block_done))

endmodule

bind multi_axis_bresenham_stepper mabs_checker u_mabs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .step_bits     (step_bits),
    .block_done    (block_done),
    .idle          (idle),
    .load_rejected (load_rejected)
);
